@@ rtl/bit_pkg.sv @@
`default_nettype none

package bit_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [8:0]  DIM_RESET = 9'd256;
    localparam logic [16:0] PASS_MAX  = 17'h1FFFF;
    localparam logic [3:0]  NB_MIN    = 4'd2;
    localparam logic [3:0]  NB_MAX    = 4'd6;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] row;
        logic [7:0] col;
        logic       pixel_in;
    } t_in;

    typedef struct packed {
        logic        result_kind;
        logic        pixel_out;
        logic [16:0] pass_count;
    } t_out;

    // one column of the three-row window
    typedef struct packed {
        logic a;
        logic m;
        logic b;
    } t_col;

    typedef struct packed {
        logic shift;
        logic sub2;
    } t_ctrl;

endpackage

`default_nettype wire

@@ rtl/bit_cell.sv @@
`default_nettype none

module bit_cell (
    input  wire logic          i_clk,
    input  wire bit_pkg::t_ctrl i_ctrl,
    input  wire logic          i_below,
    input  wire bit_pkg::t_col i_left,
    input  wire bit_pkg::t_col i_right,
    input  wire logic          i_interior,
    output bit_pkg::t_col      o_col,
    output logic               o_remove
);

    logic       r_above;
    logic       r_mid;
    logic [7:0] p;
    logic [3:0] cnt;
    logic [3:0] trans;
    logic       tests;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_above <= r_mid;
            r_mid   <= i_below;
        end
    end

    // ring p2..p9 starting at the pixel above
    assign p = {i_left.a, i_left.m, i_left.b, i_below,
                i_right.b, i_right.m, i_right.a, r_above};

    always_comb begin
        cnt   = '0;
        trans = '0;
        for (int k = 0; k < 8; k++) begin
            cnt   = cnt + 4'(p[k]);
            trans = trans + 4'(!p[k] && p[(k + 1) & 7]);
        end
    end

    always_comb begin
        if (i_ctrl.sub2) begin
            tests = !(p[0] && p[2] && p[6]) && !(p[0] && p[4] && p[6]);
        end else begin
            tests = !(p[0] && p[2] && p[4]) && !(p[2] && p[4] && p[6]);
        end
    end

    assign o_remove = r_mid && i_interior && (cnt >= bit_pkg::NB_MIN)
                      && (cnt <= bit_pkg::NB_MAX) && (trans == 4'd1) && tests;

    assign o_col.a = r_above;
    assign o_col.m = r_mid;
    assign o_col.b = i_below;

endmodule

`default_nettype wire

@@ rtl/bit_row.sv @@
`default_nettype none

module bit_row #(
    parameter int MAX_WIDTH = 256,
    parameter int WW        = 9
) (
    input  wire logic                 i_clk,
    input  wire bit_pkg::t_ctrl       i_ctrl,
    input  wire logic [MAX_WIDTH-1:0] i_below,
    input  wire logic [WW-1:0]        i_width,
    output logic      [MAX_WIDTH-1:0] o_mid,
    output logic      [MAX_WIDTH-1:0] o_remove
);

    bit_pkg::t_col cols [MAX_WIDTH];

    for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_cell
        bit_pkg::t_col left;
        bit_pkg::t_col right;
        logic          interior;

        if (c == 0) begin : g_l0
            assign left = '0;
        end else begin : g_l
            assign left = cols[c-1];
        end
        if (c == MAX_WIDTH - 1) begin : g_r0
            assign right = '0;
        end else begin : g_r
            assign right = cols[c+1];
        end

        // border columns of the used area stay
        assign interior = (c >= 1) && ((c + 2) <= 32'(i_width));

        bit_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (i_ctrl),
            .i_below    (i_below[c]),
            .i_left     (left),
            .i_right    (right),
            .i_interior (interior),
            .o_col      (cols[c]),
            .o_remove   (o_remove[c])
        );

        assign o_mid[c] = cols[c].m;
    end

endmodule

`default_nettype wire

@@ rtl/binary_image_thinning_unit.sv @@
`default_nettype none

// Binary image thinning unit (Zhang-Suen). The image lives in a row-wide memory of
// MAX_HEIGHT words of MAX_WIDTH bits. A pixel write goes straight into the memory;
// a read passes through a registered memory read, then a registered reply. A run
// sweeps the used rows through a row of pixel cells, one row per cycle: each
// sub-iteration reads every used row once and writes back each thinned row behind
// the read of the row below it. While a run or read is in progress no new request
// is taken; writes are taken whenever the unit is idle.

module binary_image_thinning_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire bit_pkg::t_in   i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output bit_pkg::t_out       o_out_data,
    input  wire logic           i_out_stall,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_index,
    input  wire logic [8:0]     i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_START, S_SWEEP} t_state;

    t_state                r_state;
    logic [8:0]            r_width;
    logic [8:0]            r_height;
    logic                  r_sub2;
    logic                  r_removed;
    logic [16:0]           r_pass;
    logic [HW-1:0]         r_rd_row;
    logic                  r_dv;
    logic [HW-1:0]         r_dk;
    logic [CW-1:0]         r_rcol;
    logic                  r_rinside;
    logic                  r_out_valid;
    bit_pkg::t_out         r_out;
    logic [MAX_WIDTH-1:0]  r_rdata;
    logic [MAX_WIDTH-1:0]  mem [MAX_HEIGHT];

    logic                  accept;
    logic                  in_inside;
    logic [RW-1:0]         in_row;
    logic [CW-1:0]         in_col;
    logic [WW-1:0]         used_w;
    logic [HW-1:0]         used_h;
    logic                  small_img;
    logic                  issue;
    logic                  wr_row;
    logic                  sweep_done;
    logic                  any_remove;
    logic [16:0]           n_pass;
    logic [RW-1:0]         raddr;
    logic [RW-1:0]         waddr;
    bit_pkg::t_ctrl        ctrl;
    logic [MAX_WIDTH-1:0]  mid_row;
    logic [MAX_WIDTH-1:0]  remove;

    assign o_in_stall = (r_state != S_IDLE) ||
                        (r_out_valid && ((i_in_data.cmd == bit_pkg::CMD_READ) ||
                                         (i_in_data.cmd == bit_pkg::CMD_RUN)));
    assign accept     = i_in_valid && !o_in_stall;
    assign in_inside  = (32'(i_in_data.row) < MAX_HEIGHT) && (32'(i_in_data.col) < MAX_WIDTH);
    assign in_row     = RW'(i_in_data.row);
    assign in_col     = CW'(i_in_data.col);

    assign used_w    = (32'(r_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(r_width);
    assign used_h    = (32'(r_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(r_height);
    assign small_img = (32'(used_w) < 3) || (32'(used_h) < 3);

    assign issue      = (r_state == S_SWEEP) && (r_rd_row < used_h);
    assign wr_row     = r_dv && (32'(r_dk) >= 2);
    assign sweep_done = r_dv && (r_dk == used_h - HW'(1));
    assign any_remove = wr_row && (|remove);
    assign n_pass     = (r_pass == bit_pkg::PASS_MAX) ? r_pass : r_pass + 17'd1;

    assign raddr = (r_state == S_IDLE) ? in_row : r_rd_row[RW-1:0];
    assign waddr = RW'(r_dk - HW'(1));

    assign ctrl.shift = r_dv;
    assign ctrl.sub2  = r_sub2;

    bit_row #(
        .MAX_WIDTH (MAX_WIDTH),
        .WW        (WW)
    ) u_row (
        .i_clk    (i_clk),
        .i_ctrl   (ctrl),
        .i_below  (r_rdata),
        .i_width  (used_w),
        .o_mid    (mid_row),
        .o_remove (remove)
    );

    // image memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[raddr];
        if (accept && (i_in_data.cmd == bit_pkg::CMD_WRITE) && in_inside) begin
            mem[in_row][in_col] <= i_in_data.pixel_in;
        end else if (wr_row) begin
            mem[waddr] <= mid_row & ~remove;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= bit_pkg::DIM_RESET;
            r_height    <= bit_pkg::DIM_RESET;
            r_sub2      <= 1'b0;
            r_removed   <= 1'b0;
            r_pass      <= '0;
            r_rd_row    <= '0;
            r_dv        <= 1'b0;
            r_dk        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bit_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                    bit_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_dv <= issue;
            r_dk <= r_rd_row;
            if (issue) begin
                r_rd_row <= r_rd_row + HW'(1);
            end
            // the end of a pass decides on its own
            if (any_remove && !(sweep_done && r_sub2)) begin
                r_removed <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_in_data.cmd)
                            bit_pkg::CMD_READ: begin
                                r_rcol    <= in_col;
                                r_rinside <= in_inside;
                                r_state   <= S_READ;
                            end
                            bit_pkg::CMD_RUN: begin
                                r_pass    <= '0;
                                r_sub2    <= 1'b0;
                                r_removed <= 1'b0;
                                r_state   <= S_START;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    r_out_valid       <= 1'b1;
                    r_out.result_kind <= bit_pkg::KIND_READ;
                    r_out.pixel_out   <= r_rdata[r_rcol] & r_rinside;
                    r_out.pass_count  <= '0;
                    r_state           <= S_IDLE;
                end
                S_START: begin
                    if (small_img) begin
                        // no interior pixels: one pass that changes nothing
                        r_pass            <= n_pass;
                        r_out_valid       <= 1'b1;
                        r_out.result_kind <= bit_pkg::KIND_REPORT;
                        r_out.pixel_out   <= 1'b0;
                        r_out.pass_count  <= n_pass;
                        r_state           <= S_IDLE;
                    end else begin
                        r_rd_row <= '0;
                        r_state  <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (sweep_done) begin
                        if (!r_sub2) begin
                            r_sub2  <= 1'b1;
                            r_state <= S_START;
                        end else begin
                            r_sub2 <= 1'b0;
                            r_pass <= n_pass;
                            if (r_removed || any_remove) begin
                                r_removed <= 1'b0;
                                r_state   <= S_START;
                            end else begin
                                r_out_valid       <= 1'b1;
                                r_out.result_kind <= bit_pkg::KIND_REPORT;
                                r_out.pixel_out   <= 1'b0;
                                r_out.pass_count  <= n_pass;
                                r_state           <= S_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
